// ===== design/sqlkpd_pkg.sv =====
// shared types, constants and keyword tables for the show-trace prefix detector
// no dependencies; imported by every module of the block
package sqlkpd_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic       PHASE_SHOW  = 1'b0;
  localparam logic       PHASE_TRACE = 1'b1;
  localparam logic [2:0] LEN_SHOW    = 3'd4;
  localparam logic [2:0] LEN_TRACE   = 3'd5;

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_SLASH,
    MODE_DASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_WORD,
    MODE_DONE,
    MODE_FAIL
  } scan_mode_t;

  // classified byte as it travels from the front to the back
  typedef struct packed {
    logic [7:0] fold;
    logic       space;
    logic       slash;
    logic       dash;
    logic       hash;
    logic       star;
    logic       lf;
    logic       word;
    logic       last;
  } byte_info_t;

  function automatic logic [7:0] kw_char(input logic phase, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (phase == PHASE_SHOW) begin
      unique case (pos)
        3'd0: ch = "s";
        3'd1: ch = "h";
        3'd2: ch = "o";
        3'd3: ch = "w";
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (pos)
        3'd0: ch = "t";
        3'd1: ch = "r";
        3'd2: ch = "a";
        3'd3: ch = "c";
        3'd4: ch = "e";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic phase);
    return (phase == PHASE_SHOW) ? LEN_SHOW : LEN_TRACE;
  endfunction

endpackage

// ===== design/sqlkpd_front.sv =====
// front stage: accepts text bytes and classifies them into byte_info_t
// depends on sqlkpd_pkg
module sqlkpd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   is_last,
  output logic                   f_valid,
  output sqlkpd_pkg::byte_info_t f_info,
  input  logic                   q_full
);
  import sqlkpd_pkg::*;

  byte_info_t info_next;
  logic       accept;
  logic       push;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;

  always_comb begin
    info_next.fold  = (text_byte >= "A" && text_byte <= "Z") ? text_byte + 8'd32 : text_byte;
    info_next.space = text_byte == CH_SPACE || text_byte == CH_TAB || text_byte == CH_LF ||
                      text_byte == CH_CR || text_byte == CH_FF;
    info_next.slash = text_byte == CH_SLASH;
    info_next.dash  = text_byte == CH_DASH;
    info_next.hash  = text_byte == CH_HASH;
    info_next.star  = text_byte == CH_STAR;
    info_next.lf    = text_byte == CH_LF;
    info_next.word  = (text_byte >= "a" && text_byte <= "z") ||
                      (text_byte >= "A" && text_byte <= "Z") ||
                      (text_byte >= "0" && text_byte <= "9") ||
                      text_byte == CH_USCORE || text_byte == CH_DOLLAR;
    info_next.last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_info <= info_next;
    end
  end

endmodule

// ===== design/sqlkpd_queue.sv =====
// short queue of classified bytes between the front and the back
// depends on sqlkpd_pkg
module sqlkpd_queue #(
  parameter int QUEUE_DEPTH = sqlkpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sqlkpd_pkg::byte_info_t push_info,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output sqlkpd_pkg::byte_info_t head_info
);
  import sqlkpd_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  byte_info_t      mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = count == CntFull;
  assign head_valid = count != '0;
  assign head_info  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_info;
    end
  end

endmodule

// ===== design/sqlkpd_back.sv =====
// back end: keyword scanner state machine and the result register
// depends on sqlkpd_pkg
module sqlkpd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  sqlkpd_pkg::byte_info_t head_info,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   is_match
);
  import sqlkpd_pkg::*;

  scan_mode_t mode;
  scan_mode_t mode_next;
  scan_mode_t step_mode;
  scan_mode_t sk_mode;
  logic       phase;
  logic       phase_next;
  logic       step_phase;
  logic       sk_phase;
  logic       sk_hit;
  logic [2:0] kpos;
  logic [2:0] kpos_next;
  logic [2:0] step_kpos;
  logic       star_seen;
  logic       star_seen_next;
  logic       step_star;
  logic       match_now;

  // where a keyword may start: the end of show hands over to trace
  assign sk_phase = (mode == MODE_WORD) ? PHASE_TRACE : phase;
  assign sk_hit   = head_info.fold == kw_char(sk_phase, 3'd0);

  always_comb begin
    priority if (head_info.space) begin
      sk_mode = MODE_SKIP;
    end else if (head_info.slash) begin
      sk_mode = MODE_SLASH;
    end else if (head_info.dash) begin
      sk_mode = MODE_DASH;
    end else if (head_info.hash) begin
      sk_mode = MODE_LINE;
    end else if (sk_hit) begin
      sk_mode = MODE_WORD;
    end else begin
      sk_mode = MODE_FAIL;
    end
  end

  // next state
  always_comb begin
    step_mode  = mode;
    step_phase = phase;
    step_kpos  = kpos;
    step_star  = star_seen;
    unique case (mode)
      MODE_SKIP: begin
        step_mode = sk_mode;
        if (sk_mode == MODE_WORD) begin
          step_kpos = 3'd1;
        end
      end
      MODE_SLASH: begin
        if (head_info.star) begin
          step_star = 1'b0;
          step_mode = MODE_BLOCK;
        end else begin
          step_mode = MODE_FAIL;
        end
      end
      MODE_DASH: begin
        step_mode = head_info.dash ? MODE_LINE : MODE_FAIL;
      end
      MODE_LINE: begin
        if (head_info.lf) begin
          step_mode = MODE_SKIP;
        end
      end
      MODE_BLOCK: begin
        if (star_seen && head_info.slash) begin
          step_star = 1'b0;
          step_mode = MODE_SKIP;
        end else begin
          step_star = head_info.star;
        end
      end
      MODE_WORD: begin
        if (kpos < kw_len(phase)) begin
          if (head_info.fold == kw_char(phase, kpos)) begin
            step_kpos = kpos + 3'd1;
          end else begin
            step_mode = MODE_FAIL;
          end
        end else if (head_info.word) begin
          step_mode = MODE_FAIL;
        end else if (phase == PHASE_SHOW) begin
          step_phase = PHASE_TRACE;
          step_kpos  = (sk_mode == MODE_WORD) ? 3'd1 : 3'd0;
          step_mode  = sk_mode;
        end else begin
          step_mode = MODE_DONE;
        end
      end
      MODE_DONE: begin
      end
      MODE_FAIL: begin
      end
    endcase

    // the last byte returns the scanner to its start for the next statement
    if (head_info.last) begin
      mode_next      = MODE_SKIP;
      phase_next     = PHASE_SHOW;
      kpos_next      = 3'd0;
      star_seen_next = 1'b0;
    end else begin
      mode_next      = step_mode;
      phase_next     = step_phase;
      kpos_next      = step_kpos;
      star_seen_next = step_star;
    end
  end

  // outputs
  always_comb begin
    pop       = head_valid && (!head_info.last || !out_valid || !out_stall);
    match_now = step_mode == MODE_DONE ||
                (step_mode == MODE_WORD && step_phase == PHASE_TRACE && step_kpos == LEN_TRACE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SKIP;
      phase     <= PHASE_SHOW;
      kpos      <= 3'd0;
      star_seen <= 1'b0;
    end else if (pop) begin
      mode      <= mode_next;
      phase     <= phase_next;
      kpos      <= kpos_next;
      star_seen <= star_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_info.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_info.last) begin
      is_match <= match_now;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    pop && head_info.last |=> mode == MODE_SKIP && phase == PHASE_SHOW && kpos == 3'd0)
    else $error("scanner not back at start after last byte");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    pop && !head_info.last && mode == MODE_DONE |=> mode == MODE_DONE)
    else $error("completed match lost before last byte");

  a_kpos_range: assert property (@(posedge clk) disable iff (rst)
    kpos <= LEN_TRACE && (phase == PHASE_TRACE || kpos <= LEN_SHOW))
    else $error("keyword position beyond keyword length");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_match))
    else $error("pending result overwritten");

endmodule

// ===== design/sql_keyword_prefix_detector_top.sv =====
// top level of the show-trace prefix detector: front, queue and back
// depends on sqlkpd_pkg, sqlkpd_front, sqlkpd_queue, sqlkpd_back
//
// usage: statement text enters one byte per item on the input channel
// (text_byte, is_last, in_valid/in_stall). the byte marked is_last closes the
// statement and yields exactly one result item on the output channel
// (is_match, out_valid/out_stall); other bytes yield nothing. is_match is 1
// when the text opens with the keywords show then trace, case-insensitive,
// with white space and comments allowed before each keyword.
// throughput: one byte per cycle sustained while no result is held by out_stall;
// the scanner state advances one byte a cycle in the back end.
// result path: the last byte moves from the front register into the queue, then
// from the queue head into the result register; it waits longer if the queue
// holds earlier bytes.
// reset: rst is synchronous, active high; it empties the queue, drops any
// pending result and puts the scanner at the start of a statement.
// stall: while out_stall holds a result, the back keeps consuming bytes up to
// the next last byte; then the queue fills and in_stall rises.
module sql_keyword_prefix_detector_top #(
  parameter int QUEUE_DEPTH = sqlkpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_match
);
  import sqlkpd_pkg::*;

  logic       f_valid;
  byte_info_t f_info;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  byte_info_t head_info;

  sqlkpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .is_last   (is_last),
    .f_valid   (f_valid),
    .f_info    (f_info),
    .q_full    (q_full)
  );

  sqlkpd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_info  (f_info),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_info  (head_info)
  );

  sqlkpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_info  (head_info),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_match   (is_match)
  );

endmodule

// ===== verif/tb_sql_keyword_prefix_detector_top.sv =====
// testbench for sql_keyword_prefix_detector_top: sends statement text byte by byte and
// checks each is_match against an in-bench show-trace scanner; depends on sqlkpd_pkg
module tb_sql_keyword_prefix_detector_top;
  import sqlkpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [31:0] SHOW_TXT  = "show";
  localparam logic [39:0] TRACE_TXT = "trace";

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic       is_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       is_match;

  sql_keyword_prefix_detector_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_match  (is_match)
  );

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   fail_count    = 0;
  int   quiet_cycles  = 0;
  logic hold_on       = 1'b0;
  event hold_ev;

  logic expected_match_q[$];
  logic exp_match;
  logic [7:0] stmt_q[$];

  // scanner state of the prediction
  logic       in_trace;
  scan_mode_t scan_st;
  logic [2:0] kw_pos;
  logic       star_flag;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_USCORE || c == CH_DOLLAR;
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] kw_letter(input logic ph, input int pos);
    return ph ? TRACE_TXT[8*(4-pos) +: 8] : SHOW_TXT[8*(3-pos) +: 8];
  endfunction

  task automatic clear_scan();
    in_trace  = PHASE_SHOW;
    scan_st   = MODE_SKIP;
    kw_pos    = 3'd0;
    star_flag = 1'b0;
  endtask

  // byte where a keyword may begin, after any skipping
  task automatic start_keyword(input logic ph, input logic [7:0] c);
    in_trace = ph;
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF) begin
      scan_st = MODE_SKIP;
    end else if (c == CH_SLASH) begin
      scan_st = MODE_SLASH;
    end else if (c == CH_DASH) begin
      scan_st = MODE_DASH;
    end else if (c == CH_HASH) begin
      scan_st = MODE_LINE;
    end else if (lower_case(c) == kw_letter(ph, 0)) begin
      kw_pos  = 3'd1;
      scan_st = MODE_WORD;
    end else begin
      scan_st = MODE_FAIL;
    end
  endtask

  task automatic scan_text_byte(input logic [7:0] c, input logic last);
    case (scan_st)
      MODE_SKIP: start_keyword(in_trace, c);
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          star_flag = 1'b0;
          scan_st   = MODE_BLOCK;
        end else begin
          scan_st = MODE_FAIL;
        end
      end
      MODE_DASH: scan_st = (c == CH_DASH) ? MODE_LINE : MODE_FAIL;
      MODE_LINE: begin
        if (c == CH_LF) scan_st = MODE_SKIP;
      end
      MODE_BLOCK: begin
        if (star_flag && c == CH_SLASH) begin
          star_flag = 1'b0;
          scan_st   = MODE_SKIP;
        end else begin
          star_flag = (c == CH_STAR);
        end
      end
      MODE_WORD: begin
        if (kw_pos < (in_trace ? LEN_TRACE : LEN_SHOW)) begin
          if (lower_case(c) == kw_letter(in_trace, kw_pos)) kw_pos = kw_pos + 3'd1;
          else scan_st = MODE_FAIL;
        end else if (is_ident(c)) begin
          scan_st = MODE_FAIL;
        end else if (in_trace == PHASE_SHOW) begin
          kw_pos = 3'd0;
          start_keyword(PHASE_TRACE, c);
        end else begin
          scan_st = MODE_DONE;
        end
      end
      default: ; // done stays done, fail stays fail
    endcase
    if (last) begin
      expected_match_q.push_back(scan_st == MODE_DONE ||
        (in_trace == PHASE_TRACE && scan_st == MODE_WORD && kw_pos == LEN_TRACE));
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_text_byte(b, last);
  endtask

  task automatic send_statement();
    foreach (stmt_q[i]) send_item(stmt_q[i], i == stmt_q.size() - 1);
    stmt_q.delete();
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_match_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver: random stall plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    forever begin
      @(hold_ev);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_match_q.size() == 0) begin
        report_mismatch($sformatf("result is_match=%0b with none expected", is_match));
      end else begin
        exp_match = expected_match_q.pop_front();
        if (is_match !== exp_match)
          report_mismatch($sformatf("is_match=%0b expected %0b", is_match, exp_match));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- text builders

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) stmt_q.push_back(s[i]);
  endtask

  task automatic put_keyword(input string kw);
    logic [7:0] c;
    for (int i = 0; i < kw.len(); i++) begin
      c = kw[i];
      if ($urandom_range(1)) c = c - 8'd32;
      stmt_q.push_back(c);
    end
  endtask

  // random bytes with one value kept out (line feed, or slash in an open comment)
  task automatic put_filler(input int n, input logic [7:0] banned);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(255));
      stmt_q.push_back(c == banned ? 8'h78 : c);
    end
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] word_byte();
    case ($urandom_range(3))
      0: return 8'h61 + 8'($urandom_range(25));
      1: return 8'h41 + 8'($urandom_range(25));
      2: return 8'h30 + 8'($urandom_range(9));
      default: return $urandom_range(1) ? CH_USCORE : CH_DOLLAR;
    endcase
  endfunction

  function automatic logic [7:0] non_word_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_ident(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  // white space and comments that may stand before a keyword
  task automatic put_gap(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) begin
      case ($urandom_range(5))
        0, 1: stmt_q.push_back(blank_byte());
        2: begin
          put_text("/*");
          repeat ($urandom_range(4)) begin
            case ($urandom_range(5))
              0, 1: stmt_q.push_back(CH_STAR);
              2: stmt_q.push_back(CH_SLASH);
              default: stmt_q.push_back(8'($urandom_range(255)));
            endcase
          end
          put_text("*/");
        end
        3: begin
          put_text("--");
          put_filler($urandom_range(5), CH_LF);
          stmt_q.push_back(CH_LF);
        end
        4: begin
          stmt_q.push_back(CH_HASH);
          put_filler($urandom_range(5), CH_LF);
          stmt_q.push_back(CH_LF);
        end
        default: repeat ($urandom_range(3, 1)) stmt_q.push_back(blank_byte());
      endcase
    end
  endtask

  task automatic build_statement();
    int r;
    int keep;
    r = $urandom_range(99);
    if (r < 12) begin
      repeat ($urandom_range(10, 1)) stmt_q.push_back(8'($urandom_range(255)));
    end else if (r < 20) begin
      put_gap(0, 1);
      case ($urandom_range(3))
        0: begin
          // comment never closed
          put_text("/*");
          put_filler($urandom_range(6), CH_SLASH);
        end
        1: begin
          stmt_q.push_back(CH_SLASH);
          put_keyword("show");
          put_text(" trace");
        end
        2: begin
          stmt_q.push_back(CH_DASH);
          put_keyword("show");
          put_text(" trace");
        end
        default: begin
          put_keyword("show");
          stmt_q.push_back(8'($urandom_range(255, 128)));
          put_keyword("trace");
        end
      endcase
    end else begin
      put_gap(0, 2);
      put_keyword("show");
      case ($urandom_range(9))
        6: stmt_q.push_back(non_word_byte());
        7: stmt_q.push_back(word_byte());
        8: ;
        default: put_gap(1, 3);
      endcase
      if ($urandom_range(9) != 0) put_keyword("trace");
      else put_keyword("trac");
      case ($urandom_range(5))
        2: begin
          stmt_q.push_back(non_word_byte());
          put_filler($urandom_range(6), CH_LF);
        end
        3: stmt_q.push_back(word_byte());
        4: put_gap(1, 2);
        5: stmt_q.push_back(non_word_byte());
        default: ;
      endcase
      if ($urandom_range(9) == 0)
        stmt_q[$urandom_range(stmt_q.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
        keep = $urandom_range(stmt_q.size(), 1);
        while (stmt_q.size() > keep) void'(stmt_q.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic check_keyword_forms();
    send_idle_pct = 0;
    stall_pct     = 0;
    put_text("SHOW TrAcE");
    send_statement();
    stmt_q.push_back(CH_FF);
    stmt_q.push_back(CH_CR);
    put_text("show");
    stmt_q.push_back(CH_LF);
    stmt_q.push_back(CH_TAB);
    put_text("trace");
    send_statement();
    put_text("/*c*/show/***/trace;x");
    send_statement();
    put_text("--a");
    stmt_q.push_back(CH_LF);
    put_text("show#b");
    stmt_q.push_back(CH_LF);
    put_text("trace");
    send_statement();
    put_text("show trace_");
    send_statement();
    put_text("show$ trace");
    send_statement();
    put_text("/* open *");
    send_statement();
    put_text("/show trace");
    send_statement();
    put_text("-show trace");
    send_statement();
    put_text("show");
    stmt_q.push_back(8'h80);
    put_text("trace");
    send_statement();
    stmt_q.push_back(8'hff);
    send_statement();
    stmt_q.push_back(8'h00);
    send_statement();
    put_text("show");
    send_statement();
    wait_results();
  endtask

  task automatic run_random_traffic(input int n_bytes, input int idle_pct, input int hold_pct);
    int sent;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    sent          = 0;
    while (sent < n_bytes) begin
      build_statement();
      sent += stmt_q.size();
      send_statement();
    end
    // sender pauses until every result is back
    wait_results();
  endtask

  // output held off long enough that the queue fills and the input stalls
  task automatic check_queue_fill();
    send_idle_pct = 0;
    stall_pct     = 0;
    -> hold_ev;
    repeat (30) begin
      put_gap(0, 1);
      put_keyword("show");
      put_gap(1, 1);
      put_keyword("trace");
      send_statement();
    end
    wait_results();
  endtask

  initial begin
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    check_keyword_forms();
    run_random_traffic(280, 0, 0);
    run_random_traffic(280, 62, 0);
    run_random_traffic(280, 0, 62);
    run_random_traffic(280, 36, 36);
    check_queue_fill();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
